// ===== hdl/gda_pkg.sv =====
// Shared types, constants and calendar tables for the Gregorian date unit.
// Used by gda_year and gregorian_date_arithmetic; depends on nothing else.
package gda_pkg;

  // Operation codes carried in the input tuser
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_CMP = 2'd2;

  // Reciprocal of 100 for floor(x / 100), exact for x below 199729
  localparam logic [17:0] RECIP100    = 18'd167773;
  localparam int          RECIP_SHIFT = 24;

  localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;
  localparam logic [3:0] MONTH_FEB     = 4'd2;
  localparam logic [3:0] MONTH_DEC     = 4'd12;

  localparam logic [4:0] MONTH_DAYS [0:11] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Days in the year before the first of each month, common year
  localparam logic [8:0] CUM_DAYS [0:11] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Microcode step addresses
  typedef logic [4:0] step_t;

  localparam step_t S_IDLE     = 5'd0;
  localparam step_t S_DIV_A    = 5'd1;
  localparam step_t S_YFD_A    = 5'd2;
  localparam step_t S_DATE_A   = 5'd3;
  localparam step_t S_SEL_B    = 5'd4;
  localparam step_t S_DIV_B    = 5'd5;
  localparam step_t S_YFD_B    = 5'd6;
  localparam step_t S_DATE_B   = 5'd7;
  localparam step_t S_SET_LAST = 5'd8;
  localparam step_t S_DIV_L    = 5'd9;
  localparam step_t S_YFD_L    = 5'd10;
  localparam step_t S_TARGET   = 5'd11;
  localparam step_t S_TRY      = 5'd12;
  localparam step_t S_DIV_T    = 5'd13;
  localparam step_t S_YFD_T    = 5'd14;
  localparam step_t S_KEEP     = 5'd15;
  localparam step_t S_SET_LO   = 5'd16;
  localparam step_t S_DIV_R    = 5'd17;
  localparam step_t S_YFD_R    = 5'd18;
  localparam step_t S_MSTART   = 5'd19;
  localparam step_t S_MSTEP    = 5'd20;
  localparam step_t S_OUT      = 5'd21;
  localparam step_t S_LAST     = S_OUT;

  // Datapath operation of one step
  typedef enum logic [3:0] {
    DP_LOAD,
    DP_DIV,
    DP_YFD,
    DP_DATE_A,
    DP_SEL_B,
    DP_DATE_B,
    DP_SET_LAST,
    DP_TARGET,
    DP_TRY,
    DP_KEEP,
    DP_SET_LO,
    DP_MSTART,
    DP_MSTEP,
    DP_OUT
  } dp_op_t;

  // Jump condition of one step
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_ARITH,
    C_BIT_MORE,
    C_MON_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } ctl_word_t;

  // Controls of the year-start unit
  typedef struct packed {
    logic div_en;
    logic yfd_en;
  } yu_ctl_t;

  // Control store
  function automatic ctl_word_t ucode(input step_t pc);
    ctl_word_t w;
    w = '{op: DP_OUT, cond: C_NEXT, target: S_IDLE};
    case (pc)
      S_IDLE:     w = '{op: DP_LOAD,     cond: C_NO_IN,    target: S_IDLE};
      S_DIV_A:    w = '{op: DP_DIV,      cond: C_NEXT,     target: S_IDLE};
      S_YFD_A:    w = '{op: DP_YFD,      cond: C_NEXT,     target: S_IDLE};
      S_DATE_A:   w = '{op: DP_DATE_A,   cond: C_ARITH,    target: S_SET_LAST};
      S_SEL_B:    w = '{op: DP_SEL_B,    cond: C_NEXT,     target: S_IDLE};
      S_DIV_B:    w = '{op: DP_DIV,      cond: C_NEXT,     target: S_IDLE};
      S_YFD_B:    w = '{op: DP_YFD,      cond: C_NEXT,     target: S_IDLE};
      S_DATE_B:   w = '{op: DP_DATE_B,   cond: C_ALWAYS,   target: S_OUT};
      S_SET_LAST: w = '{op: DP_SET_LAST, cond: C_NEXT,     target: S_IDLE};
      S_DIV_L:    w = '{op: DP_DIV,      cond: C_NEXT,     target: S_IDLE};
      S_YFD_L:    w = '{op: DP_YFD,      cond: C_NEXT,     target: S_IDLE};
      S_TARGET:   w = '{op: DP_TARGET,   cond: C_NEXT,     target: S_IDLE};
      S_TRY:      w = '{op: DP_TRY,      cond: C_NEXT,     target: S_IDLE};
      S_DIV_T:    w = '{op: DP_DIV,      cond: C_NEXT,     target: S_IDLE};
      S_YFD_T:    w = '{op: DP_YFD,      cond: C_NEXT,     target: S_IDLE};
      S_KEEP:     w = '{op: DP_KEEP,     cond: C_BIT_MORE, target: S_TRY};
      S_SET_LO:   w = '{op: DP_SET_LO,   cond: C_NEXT,     target: S_IDLE};
      S_DIV_R:    w = '{op: DP_DIV,      cond: C_NEXT,     target: S_IDLE};
      S_YFD_R:    w = '{op: DP_YFD,      cond: C_NEXT,     target: S_IDLE};
      S_MSTART:   w = '{op: DP_MSTART,   cond: C_NEXT,     target: S_IDLE};
      S_MSTEP:    w = '{op: DP_MSTEP,    cond: C_MON_MORE, target: S_MSTEP};
      S_OUT:      w = '{op: DP_OUT,      cond: C_OUT_BUSY, target: S_OUT};
      default:    w = '{op: DP_OUT,      cond: C_NEXT,     target: S_IDLE};
    endcase
    return w;
  endfunction

  // Length of month m (1..12) given the leap flag of its year
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m == MONTH_FEB && leap) begin
      return FEB_LEAP_DAYS;
    end
    return MONTH_DAYS[idx];
  endfunction

  // Days in the year before the first of month m (1..12)
  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    idx = m - 4'd1;
    return CUM_DAYS[idx] + {8'd0, (leap && m > MONTH_FEB)};
  endfunction

endpackage

// ===== hdl/gda_year.sv =====
// Year-start unit: days from 1 January of year 0 to 1 January of a year,
// plus that year's leap flag, in two steps. Depends on gda_pkg.
module gda_year #(
  parameter int YEAR_BITS = 12
) (
  input  logic                   clk,
  input  gda_pkg::yu_ctl_t       ctl,
  input  logic [YEAR_BITS:0]     year,
  output logic [YEAR_BITS+8:0]   yfd,
  output logic                   leap
);

  localparam int YW    = YEAR_BITS + 1;
  localparam int DN_W  = YEAR_BITS + 9;
  localparam int FQ_W  = YW - 6;
  localparam int PR_W  = YW + 18;

  logic [PR_W-1:0] prod;
  logic [FQ_W-1:0] fq_r;
  logic [YW-1:0]   fq_ext;
  logic [YW-1:0]   hund;
  logic            whole_cent;
  logic [FQ_W-1:0] c100;
  logic [FQ_W-1:0] c100_p3;
  logic [FQ_W-1:0] c400;
  logic [YW-1:0]   y_p3;
  logic [DN_W-1:0] t365;
  logic [DN_W-1:0] yfd_nxt;
  logic            leap_nxt;
  logic [DN_W-1:0] yfd_r;
  logic            leap_r;

  // Floor of year / 100 by reciprocal multiply
  assign prod = PR_W'(year) * PR_W'(gda_pkg::RECIP100);

  // Year start: 365y + ceil(y/4) - ceil(y/100) + ceil(y/400)
  always_comb begin
    fq_ext     = YW'(fq_r);
    hund       = fq_ext * YW'(100);
    whole_cent = (hund == year);
    c100       = fq_r + FQ_W'(!whole_cent);
    c100_p3    = c100 + FQ_W'(3);
    c400       = c100_p3 >> 2;
    y_p3       = year + YW'(3);
    t365       = DN_W'(year) * DN_W'(365);
    yfd_nxt    = t365 + DN_W'(y_p3 >> 2) - DN_W'(c100) + DN_W'(c400);
    leap_nxt   = whole_cent ? (fq_r[1:0] == 2'd0) : (year[1:0] == 2'd0);
  end

  // Hold quotient, then year start and leap flag
  always_ff @(posedge clk) begin
    if (ctl.div_en) begin
      fq_r <= prod[gda_pkg::RECIP_SHIFT +: FQ_W];
    end
    if (ctl.yfd_en) begin
      yfd_r  <= yfd_nxt;
      leap_r <= leap_nxt;
    end
  end

  assign yfd  = yfd_r;
  assign leap = leap_r;

endmodule

// ===== hdl/gregorian_date_arithmetic.sv =====
// Gregorian date unit: add, subtract and compare on calendar dates.
// Top level; depends on gda_pkg and gda_year.
//
//   Channel | Direction | Payload
//   --------+-----------+--------------------------------------------------
//   in_     | request   | tuser: operation; tdata: dates A, B and day count
//   out_    | result    | tdata: result date, compare flags, gap, range flag
//
// Compare needs no year search; add and subtract also run a year search and
// then step through the months, up to 11 of them. The year search, four
// steps per year bit through the shared year-start unit, dominates their run.
// Reset clears the step counter and the output valid; no clearing pass.
// A new request is taken while a result waits; the next result holds in
// its last step until the output register is free.
module gregorian_date_arithmetic #(
  parameter int YEAR_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // day_a, month_a, year_a, day_b, month_b, year_b,
                                  // day_count, zero pad
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // res_day, res_month, res_year, is_equal, is_less,
                                  // day_gap, range_error, zero pad
);

  localparam int YW   = YEAR_BITS + 1;
  localparam int DN_W = YEAR_BITS + 9;
  localparam int BI_W = $clog2(YEAR_BITS);
  localparam logic [11:0]           YIN_MASK = 12'((32'd1 << YEAR_BITS) - 32'd1);
  localparam logic [YW-1:0]         YEAR_TOP = {1'b1, {YEAR_BITS{1'b0}}};
  localparam logic [BI_W-1:0]       BIT_TOP  = BI_W'(YEAR_BITS - 1);

  // Input fields
  logic [4:0]  in_day_a, in_day_b;
  logic [3:0]  in_month_a, in_month_b;
  logic [11:0] in_year_a, in_year_b;
  logic [15:0] in_day_count;

  assign in_day_a     = in_tdata[4:0];
  assign in_month_a   = in_tdata[8:5];
  assign in_year_a    = in_tdata[20:9];
  assign in_day_b     = in_tdata[25:21];
  assign in_month_b   = in_tdata[29:26];
  assign in_year_b    = in_tdata[41:30];
  assign in_day_count = in_tdata[57:42];

  // Sequencer and datapath registers
  gda_pkg::step_t     pc_r, pc_nxt;
  gda_pkg::ctl_word_t cw;
  gda_pkg::yu_ctl_t   yu_ctl;

  logic [1:0]      op_r;
  logic [4:0]      da_r, db_r;
  logic [3:0]      ma_r, mb_r;
  logic [11:0]     yb_r;
  logic [15:0]     cnt_r;
  logic [YW-1:0]   yw_r;
  logic [DN_W-1:0] na_r;
  logic [DN_W-1:0] tgt_r;
  logic            err_r;
  logic [YEAR_BITS-1:0] lo_r;
  logic [BI_W-1:0] bit_r;
  logic [3:0]      mon_r;
  logic [8:0]      rem_r;
  logic [4:0]      res_day_r;
  logic [3:0]      res_month_r;
  logic [11:0]     res_year_r;
  logic            eq_r, lt_r;
  logic [20:0]     gap_r;
  logic            out_valid_r;
  logic [47:0]     out_data_r;

  logic [DN_W-1:0] yfd;
  logic            leap;

  // Combinational datapath terms
  logic            accept;
  logic            out_busy;
  logic            arith;
  logic            jump;
  logic [3:0]      date_m;
  logic [4:0]      date_d;
  logic [4:0]      date_len;
  logic [4:0]      date_dc;
  logic [DN_W-1:0] date_n;
  logic [DN_W-1:0] last_n;
  logic [DN_W-1:0] cnt_ext;
  logic [DN_W-1:0] gap_full;
  logic [4:0]      mon_len;
  logic            mon_more;

  // Clamp a month field into 1..12
  function automatic logic [3:0] clamp_month(input logic [3:0] m);
    if (m == 4'd0) begin
      return 4'd1;
    end
    if (m > gda_pkg::MONTH_DEC) begin
      return gda_pkg::MONTH_DEC;
    end
    return m;
  endfunction

  assign cw        = gda_pkg::ucode(pc_r);
  assign in_tready = (pc_r == gda_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;
  assign arith     = (op_r == gda_pkg::OP_ADD) || (op_r == gda_pkg::OP_SUB);

  assign yu_ctl.div_en = (cw.op == gda_pkg::DP_DIV);
  assign yu_ctl.yfd_en = (cw.op == gda_pkg::DP_YFD);

  gda_year #(
    .YEAR_BITS (YEAR_BITS)
  ) u_year (
    .clk  (clk),
    .ctl  (yu_ctl),
    .year (yw_r),
    .yfd  (yfd),
    .leap (leap)
  );

  // Date to day number for whichever side is selected
  always_comb begin
    date_m   = (cw.op == gda_pkg::DP_DATE_B) ? mb_r : ma_r;
    date_d   = (cw.op == gda_pkg::DP_DATE_B) ? db_r : da_r;
    date_len = gda_pkg::month_len(date_m, leap);
    if (date_d == 5'd0) begin
      date_dc = 5'd1;
    end else if (date_d > date_len) begin
      date_dc = date_len;
    end else begin
      date_dc = date_d;
    end
    date_n = yfd + DN_W'(gda_pkg::cum_days(date_m, leap)) + DN_W'(date_dc) - DN_W'(1);
  end

  // Range end, count and compare distance
  assign last_n   = yfd - DN_W'(1);
  assign cnt_ext  = DN_W'(cnt_r);
  assign gap_full = (na_r < date_n) ? (date_n - na_r) : (na_r - date_n);

  // Month stepping test
  assign mon_len  = gda_pkg::month_len(mon_r, leap);
  assign mon_more = (mon_r < gda_pkg::MONTH_DEC) && (rem_r >= {4'd0, mon_len});

  // Resolve the jump condition and advance the step counter
  always_comb begin
    case (cw.cond)
      gda_pkg::C_NEXT:     jump = 1'b0;
      gda_pkg::C_ALWAYS:   jump = 1'b1;
      gda_pkg::C_NO_IN:    jump = !in_tvalid;
      gda_pkg::C_ARITH:    jump = arith;
      gda_pkg::C_BIT_MORE: jump = (bit_r != '0);
      gda_pkg::C_MON_MORE: jump = mon_more;
      gda_pkg::C_OUT_BUSY: jump = out_busy;
      default:             jump = 1'b0;
    endcase
    if (jump) begin
      pc_nxt = cw.target;
    end else if (pc_r == gda_pkg::S_LAST) begin
      pc_nxt = gda_pkg::S_IDLE;
    end else begin
      pc_nxt = pc_r + 5'd1;
    end
  end

  // Hold the step counter and the output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= gda_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cw.op == gda_pkg::DP_OUT && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: one operation per step as the control word says
  always_ff @(posedge clk) begin
    case (cw.op)
      gda_pkg::DP_LOAD: begin
        if (accept) begin
          op_r        <= in_tuser;
          da_r        <= in_day_a;
          ma_r        <= clamp_month(in_month_a);
          db_r        <= in_day_b;
          mb_r        <= clamp_month(in_month_b);
          yb_r        <= in_year_b & YIN_MASK;
          cnt_r       <= in_day_count;
          yw_r        <= YW'(in_year_a & YIN_MASK);
          err_r       <= 1'b0;
          res_day_r   <= '0;
          res_month_r <= '0;
          res_year_r  <= '0;
          eq_r        <= 1'b0;
          lt_r        <= 1'b0;
          gap_r       <= '0;
        end
      end
      gda_pkg::DP_DATE_A: begin
        na_r <= date_n;
      end
      gda_pkg::DP_SEL_B: begin
        yw_r <= YW'(yb_r);
      end
      gda_pkg::DP_DATE_B: begin
        eq_r  <= (na_r == date_n);
        lt_r  <= (na_r < date_n);
        gap_r <= 21'(gap_full);
      end
      gda_pkg::DP_SET_LAST: begin
        yw_r <= YEAR_TOP;
      end
      gda_pkg::DP_TARGET: begin
        // Clamp at the range ends and flag it
        if (op_r == gda_pkg::OP_ADD) begin
          if (cnt_ext > last_n - na_r) begin
            tgt_r <= last_n;
            err_r <= 1'b1;
          end else begin
            tgt_r <= na_r + cnt_ext;
          end
        end else begin
          if (cnt_ext > na_r) begin
            tgt_r <= '0;
            err_r <= 1'b1;
          end else begin
            tgt_r <= na_r - cnt_ext;
          end
        end
        lo_r  <= '0;
        bit_r <= BIT_TOP;
      end
      gda_pkg::DP_TRY: begin
        yw_r <= YW'(lo_r | (YEAR_BITS'(1) << bit_r));
      end
      gda_pkg::DP_KEEP: begin
        // Keep the trial bit when that year starts on or before the target
        if (yfd <= tgt_r) begin
          lo_r <= yw_r[YEAR_BITS-1:0];
        end
        bit_r <= bit_r - BI_W'(1);
      end
      gda_pkg::DP_SET_LO: begin
        yw_r <= YW'(lo_r);
      end
      gda_pkg::DP_MSTART: begin
        rem_r <= 9'(tgt_r - yfd);
        mon_r <= 4'd1;
      end
      gda_pkg::DP_MSTEP: begin
        if (mon_more) begin
          rem_r <= rem_r - {4'd0, mon_len};
          mon_r <= mon_r + 4'd1;
        end else begin
          res_day_r   <= 5'(rem_r + 9'd1);
          res_month_r <= mon_r;
          res_year_r  <= 12'(lo_r);
        end
      end
      gda_pkg::DP_OUT: begin
        if (!out_busy) begin
          out_data_r <= {3'd0, err_r, gap_r, lt_r, eq_r, res_year_r, res_month_r,
                         res_day_r};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Month stepping starts within one year's worth of days
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == gda_pkg::S_MSTEP) |-> (rem_r < 9'd366))
    else $error("month stepping remainder beyond a year");

  // Equal dates have no gap and are not earlier
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[21]) |-> (out_tdata[43:23] == 21'd0 && !out_tdata[22]))
    else $error("equal dates with nonzero gap or less flag");

  // A range error only comes with an add or subtract result
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[44]) |-> (out_tdata[8:5] != 4'd0 && out_tdata[43:21] == 23'd0))
    else $error("range error on a compare result");

  // A dated result has a valid day and month
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8:5] != 4'd0) |->
      (out_tdata[4:0] != 5'd0 && out_tdata[8:5] <= 4'd12))
    else $error("result date out of calendar range");

  // The year search ends on the last bit before month stepping
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == gda_pkg::S_SET_LO) |-> ($past(pc_r) == gda_pkg::S_KEEP && $past(bit_r) == '0))
    else $error("year search left early");

endmodule
